>>> hw/rtl/bcp_pkg.sv
// Package for the bilinear corner patch: shared widths, register indexes
// and the reciprocal table used by the rounding divider. No dependencies.
`timescale 1ns / 1ps

package bcp_pkg;

    // Field widths.
    localparam int SPAN_W  = 5;
    localparam int CORN_W  = 16;
    localparam int VAL_W   = 25;
    localparam int PROD_W  = 31;
    localparam int NUM_W   = 32;
    localparam int RECIP_W = 31;
    localparam int IDX_W   = 3;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_COL_SPAN     = 3'd0,
        REG_ROW_SPAN     = 3'd1,
        REG_TOP_LEFT     = 3'd2,
        REG_TOP_RIGHT    = 3'd3,
        REG_BOTTOM_LEFT  = 3'd4,
        REG_BOTTOM_RIGHT = 3'd5,
        REG_OFFSET       = 3'd6
    } cfg_idx_t;

    // Reciprocal of twice the span: floor((2^32 - 1) / (2 * span)).
    localparam logic [RECIP_W-1:0] RECIP_TAB [0:31] = '{
        31'd0,
        31'(64'hFFFFFFFF / 64'd2),  31'(64'hFFFFFFFF / 64'd4),
        31'(64'hFFFFFFFF / 64'd6),  31'(64'hFFFFFFFF / 64'd8),
        31'(64'hFFFFFFFF / 64'd10), 31'(64'hFFFFFFFF / 64'd12),
        31'(64'hFFFFFFFF / 64'd14), 31'(64'hFFFFFFFF / 64'd16),
        31'(64'hFFFFFFFF / 64'd18), 31'(64'hFFFFFFFF / 64'd20),
        31'(64'hFFFFFFFF / 64'd22), 31'(64'hFFFFFFFF / 64'd24),
        31'(64'hFFFFFFFF / 64'd26), 31'(64'hFFFFFFFF / 64'd28),
        31'(64'hFFFFFFFF / 64'd30), 31'(64'hFFFFFFFF / 64'd32),
        31'(64'hFFFFFFFF / 64'd34), 31'(64'hFFFFFFFF / 64'd36),
        31'(64'hFFFFFFFF / 64'd38), 31'(64'hFFFFFFFF / 64'd40),
        31'(64'hFFFFFFFF / 64'd42), 31'(64'hFFFFFFFF / 64'd44),
        31'(64'hFFFFFFFF / 64'd46), 31'(64'hFFFFFFFF / 64'd48),
        31'(64'hFFFFFFFF / 64'd50), 31'(64'hFFFFFFFF / 64'd52),
        31'(64'hFFFFFFFF / 64'd54), 31'(64'hFFFFFFFF / 64'd56),
        31'(64'hFFFFFFFF / 64'd58), 31'(64'hFFFFFFFF / 64'd60),
        31'(64'hFFFFFFFF / 64'd62)
    };

endpackage

>>> hw/rtl/bilinear_corner_patch_top.sv
// Top level of the bilinear corner patch: configuration registers, input register,
// top and bottom edge interpolators, the row interpolator and the output register.
// Depends on bcp_pkg and bcp_lerp.
//
//  Channel   Ports                                      Direction
//  input     s_valid s_ready s_col_offset s_row_offset  in
//  result    m_valid m_ready m_delta m_out_of_range     out
//  config    cfg_we cfg_idx cfg_wdata                   in
//
// One request per cycle is accepted unless stalled; each result passes through the
// input register, the two chained six-stage interpolators and the output register.
// The whole pipeline advances while the output register is empty or being taken,
// so a stall holds every stage in place.
// Reset clears the valid bits and the configuration registers.
`timescale 1ns / 1ps

module bilinear_corner_patch_top
    import bcp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_idx,
    input  logic [CORN_W-1:0]       cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [SPAN_W-1:0]       s_col_offset,
    input  logic [SPAN_W-1:0]       s_row_offset,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_delta,
    output logic                    m_out_of_range
);

    localparam int EDGE_LAT = 6;
    localparam int OOR_LAT  = 12;

    logic [SPAN_W-1:0]        col_span_reg, row_span_reg;
    logic signed [CORN_W-1:0] tl_reg, tr_reg, bl_reg, br_reg, offset_reg;

    logic                     en;
    logic                     v0_reg;
    logic [SPAN_W-1:0]        co_reg, ro_reg;
    logic                     oor0_reg;
    logic [OOR_LAT-1:0]       vld_reg;
    logic                     oor_dly_reg [0:OOR_LAT-1];
    logic [SPAN_W-1:0]        ro_dly_reg [0:EDGE_LAT-1];
    logic signed [VAL_W-1:0]  top_val, bot_val, row_val;
    logic                     m_valid_reg;
    logic signed [VAL_W-1:0]  m_delta_reg;
    logic                     m_oor_reg;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_span_reg <= '0;
            row_span_reg <= '0;
            tl_reg       <= '0;
            tr_reg       <= '0;
            bl_reg       <= '0;
            br_reg       <= '0;
            offset_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_COL_SPAN:     col_span_reg <= cfg_wdata[SPAN_W-1:0];
                REG_ROW_SPAN:     row_span_reg <= cfg_wdata[SPAN_W-1:0];
                REG_TOP_LEFT:     tl_reg       <= cfg_wdata;
                REG_TOP_RIGHT:    tr_reg       <= cfg_wdata;
                REG_BOTTOM_LEFT:  bl_reg       <= cfg_wdata;
                REG_BOTTOM_RIGHT: br_reg       <= cfg_wdata;
                REG_OFFSET:       offset_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Global advance: every stage moves when the output can take a value.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Input stage with range check.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            co_reg   <= s_col_offset;
            ro_reg   <= s_row_offset;
            oor0_reg <= (s_col_offset > col_span_reg) || (s_row_offset > row_span_reg);
        end
    end

    // Top and bottom edges across the columns.
    bcp_lerp u_top (
        .aclk  (aclk),
        .en    (en),
        .span  (col_span_reg),
        .t     (co_reg),
        .a_in  ({tl_reg[CORN_W-1], tl_reg, 8'h00}),
        .b_in  ({tr_reg[CORN_W-1], tr_reg, 8'h00}),
        .y_out (top_val)
    );

    bcp_lerp u_bot (
        .aclk  (aclk),
        .en    (en),
        .span  (col_span_reg),
        .t     (co_reg),
        .a_in  ({bl_reg[CORN_W-1], bl_reg, 8'h00}),
        .b_in  ({br_reg[CORN_W-1], br_reg, 8'h00}),
        .y_out (bot_val)
    );

    // Down the rows between the top and bottom edges.
    bcp_lerp u_row (
        .aclk  (aclk),
        .en    (en),
        .span  (row_span_reg),
        .t     (ro_dly_reg[EDGE_LAT-1]),
        .a_in  (top_val),
        .b_in  (bot_val),
        .y_out (row_val)
    );

    // Side data follows the interpolators.
    always_ff @(posedge aclk) begin
        if (en) begin
            ro_dly_reg[0]  <= ro_reg;
            oor_dly_reg[0] <= oor0_reg;
            for (int i = 1; i < EDGE_LAT; i++) begin
                ro_dly_reg[i] <= ro_dly_reg[i-1];
            end
            for (int i = 1; i < OOR_LAT; i++) begin
                oor_dly_reg[i] <= oor_dly_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[OOR_LAT-2:0], v0_reg};
        end
    end

    // Output register: add the offset, or give zero when out of range.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[OOR_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_oor_reg   <= oor_dly_reg[OOR_LAT-1];
            m_delta_reg <= oor_dly_reg[OOR_LAT-1] ? '0 :
                           row_val + {offset_reg[CORN_W-1], offset_reg, 8'h00};
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_delta        = m_delta_reg;
    assign m_out_of_range = m_oor_reg;

    // An out-of-range result always carries a zero delta.
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> m_delta == '0)
        else $error("out-of-range result with non-zero delta");

    // A result that is not taken stays, unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_delta) && $stable(m_out_of_range))
        else $error("pending result changed before it was taken");

    // While stalled, the pipeline valid bits do not move.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(vld_reg) && $stable(v0_reg))
        else $error("pipeline moved during a stall");

endmodule

>>> hw/rtl/bcp_rdiv.sv
// Four-stage divider by a small span, rounding half away from zero.
// Uses the reciprocal table from bcp_pkg.
`timescale 1ns / 1ps

module bcp_rdiv
    import bcp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic [SPAN_W-1:0]        span,
    input  logic signed [PROD_W-1:0] num,
    output logic signed [PROD_W-1:0] quo
);

    logic [SPAN_W:0]       dvs;
    logic [PROD_W-1:0]     mag;
    logic                  neg1_reg, neg2_reg, neg3_reg;
    logic [NUM_W-1:0]      n1_reg, n2_reg, n3_reg;
    logic [62:0]           p2_reg;
    logic [PROD_W-1:0]     q3_reg;
    logic [NUM_W-1:0]      qd3_reg;
    logic [NUM_W-1:0]      rem;
    logic [PROD_W-1:0]     qfix;
    logic signed [PROD_W-1:0] quo_next;
    logic signed [PROD_W-1:0] quo_reg;

    // The rounded quotient is floor((2|num| + d) / 2d).
    assign dvs = {span, 1'b0};
    assign mag = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);

    // Stage one: sign and rounded numerator.
    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg <= num[PROD_W-1];
            n1_reg   <= {mag, 1'b0} + NUM_W'(span);
        end
    end

    // Stage two: multiply by the reciprocal.
    always_ff @(posedge aclk) begin
        if (en) begin
            neg2_reg <= neg1_reg;
            n2_reg   <= n1_reg;
            p2_reg   <= 63'(n1_reg) * 63'(RECIP_TAB[span]);
        end
    end

    // Stage three: trial quotient times the divisor.
    always_ff @(posedge aclk) begin
        if (en) begin
            neg3_reg <= neg2_reg;
            n3_reg   <= n2_reg;
            q3_reg   <= p2_reg[62:32];
            qd3_reg  <= NUM_W'(p2_reg[62:32] * PROD_W'(dvs));
        end
    end

    // Stage four: the trial quotient is at most one short; fix it and sign it.
    always_comb begin
        rem      = n3_reg - qd3_reg;
        qfix     = (rem >= NUM_W'(dvs)) ? q3_reg + PROD_W'(1) : q3_reg;
        quo_next = neg3_reg ? -$signed(qfix) : $signed(qfix);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

>>> hw/rtl/bcp_lerp.sv
// Six-stage linear interpolation a + rdiv((b - a) * t, span), giving a for a
// zero span. Depends on bcp_pkg and bcp_rdiv.
`timescale 1ns / 1ps

module bcp_lerp
    import bcp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic [SPAN_W-1:0]       span,
    input  logic [SPAN_W-1:0]       t,
    input  logic signed [VAL_W-1:0] a_in,
    input  logic signed [VAL_W-1:0] b_in,
    output logic signed [VAL_W-1:0] y_out
);

    logic signed [VAL_W:0]    diff;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  a1_reg;
    logic signed [VAL_W-1:0]  a_dly_reg [0:3];
    logic signed [PROD_W-1:0] quo;
    logic signed [VAL_W-1:0]  y_reg;

    assign diff = (VAL_W+1)'(b_in) - (VAL_W+1)'(a_in);

    // Stage one: scaled difference.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(diff) * $signed({1'b0, t});
            a1_reg   <= a_in;
        end
    end

    bcp_rdiv u_rdiv (
        .aclk (aclk),
        .en   (en),
        .span (span),
        .num  (prod_reg),
        .quo  (quo)
    );

    // Base value follows the divider.
    always_ff @(posedge aclk) begin
        if (en) begin
            a_dly_reg[0] <= a1_reg;
            for (int i = 1; i < 4; i++) begin
                a_dly_reg[i] <= a_dly_reg[i-1];
            end
        end
    end

    // Final stage: add the rounded step.
    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= (span == '0) ? a_dly_reg[3] : a_dly_reg[3] + VAL_W'(quo);
        end
    end

    assign y_out = y_reg;

endmodule
